[hw/rtl/sfhf_pkg.sv]
package sfhf_pkg;

  // character codes
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
  localparam logic [7:0] CHAR_ZERO     = 8'd48;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd87;

  // frame marker bytes printed ahead of the length
  localparam logic [7:0] MARK_0 = 8'h0a;
  localparam logic [7:0] MARK_1 = 8'h0b;
  localparam logic [7:0] MARK_2 = 8'h0c;
  localparam logic [7:0] MARK_3 = 8'h0d;

  // length that marks an ack frame
  localparam logic [7:0] ACK_LEN = 8'd5;

  // header is five bytes, ten characters
  localparam logic [3:0] HDR_LAST_STEP = 4'd9;

  // frame field parser states
  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_FCF     = 13'b0000000000010,
    ST_SEQ     = 13'b0000000000100,
    ST_PANID   = 13'b0000000001000,
    ST_MACDST  = 13'b0000000010000,
    ST_MACSRC  = 13'b0000000100000,
    ST_NWKFCF  = 13'b0000001000000,
    ST_NWKSEQ  = 13'b0000010000000,
    ST_NWKSRC  = 13'b0000100000000,
    ST_NWKDST  = 13'b0001000000000,
    ST_PAYLOAD = 13'b0010000000000,
    ST_LQI     = 13'b0100000000000,
    ST_RSSI    = 13'b1000000000000
  } field_state_t;

  // print job handed from the parser to the character sequencer
  // hdr: marker plus b0 as length; else nb hex bytes (b0 then b1) and an optional newline
  typedef struct packed {
    logic       hdr;
    logic [1:0] nb;
    logic       nl;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? wide + CHAR_ZERO : wide + HEX_ALPHA_OFS;
  endfunction

endpackage

[hw/rtl/sfhf_front.sv]
module sfhf_front
  import sfhf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  output logic       push,
  output job_t       push_job,
  input  logic       q_full
);

  field_state_t state_r, state_nxt;
  logic [7:0]   rem_r, rem_nxt;
  logic         ack_r, ack_nxt;
  logic         held_valid_r, held_valid_nxt;
  logic [7:0]   held_byte_r, held_byte_nxt;
  logic         accept;
  logic         has_job;
  job_t         job;
  logic [7:0]   rem_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_job;
  assign push_job = job;

  // parse one byte, decide what it prints
  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    ack_nxt        = ack_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    has_job        = 1'b0;
    job            = '0;
    rem_dec        = rem_r - 8'd1;
    if (held_valid_r) begin
      // second byte of a two-byte field, printed first
      rem_nxt        = rem_r - 8'd2;
      held_valid_nxt = 1'b0;
      has_job        = 1'b1;
      job.nb         = 2'd2;
      job.b0         = in_byte;
      job.b1         = held_byte_r;
      job.nl         = (rem_nxt == 8'd0);
      case (state_r)
        ST_FCF:    state_nxt = ST_SEQ;
        ST_PANID:  state_nxt = ST_MACDST;
        ST_MACDST: state_nxt = ST_MACSRC;
        ST_MACSRC: state_nxt = ST_NWKFCF;
        ST_NWKSRC: state_nxt = ST_NWKDST;
        default:   state_nxt = ST_PAYLOAD;
      endcase
    end else if (rem_r == 8'd0) begin
      // length byte
      if (in_byte == ACK_LEN) begin
        ack_nxt = 1'b1;
      end
      if (in_byte == 8'd0) begin
        has_job = 1'b1;
        job.nl  = 1'b1;
      end else begin
        rem_nxt = in_byte;
        if (state_r == ST_IDLE) begin
          has_job   = 1'b1;
          job.hdr   = 1'b1;
          job.b0    = in_byte;
          state_nxt = ST_FCF;
        end
      end
    end else if (state_r == ST_IDLE) begin
      // frame resumes with count left: header, then first fcf byte held
      has_job        = 1'b1;
      job.hdr        = 1'b1;
      job.b0         = rem_r;
      state_nxt      = ST_FCF;
      held_byte_nxt  = in_byte;
      held_valid_nxt = 1'b1;
    end else if (state_r == ST_FCF || state_r == ST_PANID || state_r == ST_MACDST ||
                 state_r == ST_MACSRC || state_r == ST_NWKSRC || state_r == ST_NWKDST) begin
      // first byte of a two-byte field
      held_byte_nxt  = in_byte;
      held_valid_nxt = 1'b1;
    end else begin
      // single-byte field
      rem_nxt = rem_dec;
      has_job = 1'b1;
      job.nb  = 2'd1;
      job.b0  = in_byte;
      job.nl  = (rem_dec == 8'd0);
      case (state_r)
        ST_SEQ:     state_nxt = ack_r ? ST_LQI : ST_PANID;
        ST_NWKFCF:  state_nxt = ST_NWKSEQ;
        ST_NWKSEQ:  state_nxt = ST_NWKSRC;
        ST_PAYLOAD: begin
          if (rem_dec == 8'd2) begin
            state_nxt = ST_LQI;
          end
        end
        ST_LQI: begin
          ack_nxt   = 1'b0;
          state_nxt = ST_RSSI;
        end
        default:    state_nxt = ST_IDLE;
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rem_r        <= 8'd0;
      ack_r        <= 1'b0;
      held_valid_r <= 1'b0;
      held_byte_r  <= 8'd0;
    end else if (accept) begin
      state_r      <= state_nxt;
      rem_r        <= rem_nxt;
      ack_r        <= ack_nxt;
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
    end
  end

endmodule

[hw/rtl/sfhf_queue.sv]
module sfhf_queue
  import sfhf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/sfhf_back.sv]
module sfhf_back
  import sfhf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_last,
  input  logic       out_ready
);

  logic [3:0] step_r;
  logic       valid_r;
  logic [7:0] char_r;
  logic       last_r;
  logic       load;
  logic [7:0] cur_byte;
  logic [7:0] cur_char;
  logic       is_last;
  logic [3:0] hex_cnt;
  logic [3:0] total;

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign load      = head_valid && (!valid_r || out_ready);
  assign pop       = load && is_last;

  // pick the character at the current step of the head job
  always_comb begin
    hex_cnt  = {1'b0, head_job.nb, 1'b0};
    total    = hex_cnt + {3'b000, head_job.nl};
    cur_byte = head_job.b0;
    if (head_job.hdr) begin
      case (step_r[3:1])
        3'd0:    cur_byte = MARK_0;
        3'd1:    cur_byte = MARK_1;
        3'd2:    cur_byte = MARK_2;
        3'd3:    cur_byte = MARK_3;
        default: cur_byte = head_job.b0;
      endcase
      cur_char = step_r[0] ? hex_char(cur_byte[3:0]) : hex_char(cur_byte[7:4]);
      is_last  = (step_r == HDR_LAST_STEP);
    end else begin
      if (step_r < hex_cnt) begin
        cur_byte = step_r[1] ? head_job.b1 : head_job.b0;
        cur_char = step_r[0] ? hex_char(cur_byte[3:0]) : hex_char(cur_byte[7:4]);
      end else begin
        cur_char = CHAR_NEWLINE;
      end
      is_last = (step_r == total - 4'd1);
    end
  end

  // step counter within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
    end else if (load) begin
      step_r <= is_last ? 4'd0 : step_r + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur_char;
      last_r <= is_last;
    end
  end

endmodule

[hw/rtl/sniffed_frame_hex_formatter.sv]
// Sniffed frame hex formatter: turns a capture byte stream (length byte, then
// that many 802.15.4 bytes) into lowercase hex ASCII characters.
// Input channel: one byte per item on in_tdata. Output channel: one character
// per item on out_tdata, with out_tlast high on the final character that an
// input byte causes. Input bytes that print nothing produce no output item.
// With the queue and the output register empty, an accepted byte's job is
// written into the job queue and its first character is then loaded into
// the output register.
// Throughput: the parser takes one byte per cycle while its job queue has
// room; the character sequencer sends one character per cycle while the
// receiver takes them, and each byte prints 0 to 10 characters, typically
// 2 to 5. The single output register sets the sustained rate.
// Reset (rst_n low at a clock edge) empties the queue, drops any pending
// character and returns the parser to its idle state with a zero count.
// When the receiver stalls, the output register holds its character, the
// queue fills and in_tready drops once QUEUE_DEPTH jobs wait.
module sniffed_frame_hex_formatter
  import sfhf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  sfhf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_ready (in_tready),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  sfhf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfhf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

endmodule

[hw/rtl/sfhf_checker.sv]
module sfhf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled output holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // only hex digits and newlines leave the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'd48 && out_tdata <= 8'd57) ||
                   (out_tdata >= 8'd97 && out_tdata <= 8'd102) ||
                   (out_tdata == 8'h0a))
    else $error("output character out of range");

  // a newline always closes the characters of one byte
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'h0a |-> out_tlast)
    else $error("newline not marked last");

  // reset drops any pending output
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sniffed_frame_hex_formatter sfhf_checker u_sfhf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[bench/sniffed_frame_hex_formatter_test.sv]
module sniffed_frame_hex_formatter_test;
  import sfhf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 20;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 48;
  localparam logic [7:0] SAFE_FRAME_LEN = 8'd24;

  // parser state mirrored by the predictor
  typedef struct {
    field_state_t fs;
    logic [7:0]   rem;
    logic         ack;
    logic         held_v;
    logic [7:0]   held_b;
  } parser_t;

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } char_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  parser_t    psr;
  logic [7:0] byte_chars[$];
  char_item_t pending_chars[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  sniffed_frame_hex_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("sniffed_frame_hex_formatter: mismatch");
      $finish;
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void note_mismatch(input string what, input logic [7:0] want_ch,
                                        input logic want_last, input logic [7:0] got_ch,
                                        input logic got_last);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT)
      $display("%0t %s: expected char %h last %b, got char %h last %b",
               $realtime, what, want_ch, want_last, got_ch, got_last);
  endfunction

  // compare each output item with the oldest predicted character
  always @(posedge clk) begin : char_check
    char_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        note_mismatch("unexpected char", 8'h00, 1'b0, out_tdata, out_tlast);
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.is_last)
          note_mismatch("wrong char", want.ch, want.is_last, out_tdata, out_tlast);
      end
    end
  end

  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? CHAR_ZERO + 8'(nib) : "a" + 8'(nib) - 8'd10;
  endfunction

  function automatic void add_hex(input logic [7:0] v);
    byte_chars.push_back(nibble_ascii(v[7:4]));
    byte_chars.push_back(nibble_ascii(v[3:0]));
  endfunction

  // marker bytes then the length
  function automatic void add_frame_marker(input logic [7:0] len);
    add_hex(MARK_0);
    add_hex(MARK_1);
    add_hex(MARK_2);
    add_hex(MARK_3);
    add_hex(len);
  endfunction

  // advance the parser by one capture byte, appending its characters to byte_chars
  function automatic void format_byte(input logic [7:0] b);
    if (psr.held_v) begin
      // second byte of a two-byte field, printed first
      add_hex(b);
      add_hex(psr.held_b);
      psr.held_v = 1'b0;
      psr.rem = psr.rem - 8'd2;
      case (psr.fs)
        ST_FCF:    psr.fs = ST_SEQ;
        ST_PANID:  psr.fs = ST_MACDST;
        ST_MACDST: psr.fs = ST_MACSRC;
        ST_MACSRC: psr.fs = ST_NWKFCF;
        ST_NWKSRC: psr.fs = ST_NWKDST;
        default:   psr.fs = ST_PAYLOAD;
      endcase
      if (psr.rem == 8'd0)
        byte_chars.push_back(CHAR_NEWLINE);
    end else if (psr.rem == 8'd0) begin
      // length byte
      if (b == ACK_LEN)
        psr.ack = 1'b1;
      if (b == 8'd0) begin
        byte_chars.push_back(CHAR_NEWLINE);
      end else begin
        psr.rem = b;
        if (psr.fs == ST_IDLE) begin
          add_frame_marker(b);
          psr.fs = ST_FCF;
        end
      end
    end else begin
      // field byte; an idle parser with count left opens a new line first
      if (psr.fs == ST_IDLE) begin
        add_frame_marker(psr.rem);
        psr.fs = ST_FCF;
      end
      case (psr.fs)
        ST_FCF, ST_PANID, ST_MACDST, ST_MACSRC, ST_NWKSRC, ST_NWKDST: begin
          psr.held_b = b;
          psr.held_v = 1'b1;
        end
        default: begin
          add_hex(b);
          psr.rem = psr.rem - 8'd1;
          case (psr.fs)
            ST_SEQ:    psr.fs = psr.ack ? ST_LQI : ST_PANID;
            ST_NWKFCF: psr.fs = ST_NWKSEQ;
            ST_NWKSEQ: psr.fs = ST_NWKSRC;
            ST_PAYLOAD: begin
              if (psr.rem == 8'd2)
                psr.fs = ST_LQI;
            end
            ST_LQI: begin
              psr.ack = 1'b0;
              psr.fs = ST_RSSI;
            end
            default:   psr.fs = ST_IDLE;
          endcase
          if (psr.rem == 8'd0)
            byte_chars.push_back(CHAR_NEWLINE);
        end
      endcase
    end
  endfunction

  // offer one byte, wait for its handshake and queue the characters it must print
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    byte_chars.delete();
    format_byte(b);
    foreach (byte_chars[i])
      pending_chars.push_back('{ch: byte_chars[i], is_last: (i == byte_chars.size() - 1)});
  endtask

  task automatic wait_chars_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0)
      @(posedge clk);
  endtask

  // every field of a normal frame, extremes in the contents
  task automatic test_full_frame();
    logic [7:0] frame [19] = '{8'd18, 8'h00, 8'hff, 8'h80, 8'h34, 8'h12, 8'hff, 8'hff,
                               8'h01, 8'h00, 8'h08, 8'h7f, 8'hfe, 8'hca, 8'h00, 8'h00,
                               8'h5a, 8'hff, 8'h00};
    foreach (frame[i])
      send_byte(frame[i]);
  endtask

  // short frame stops after fcf; an ack length arrives mid-frame and is swallowed,
  // rssi then leaves count behind so the next byte reopens a line (ten chars);
  // a zero length while not idle still prints a newline
  task automatic test_frame_ends_early();
    logic [7:0] seq_bytes [10] = '{8'h02, 8'h11, 8'h22, ACK_LEN, 8'h33, 8'hc4, 8'hd9,
                                   8'hee, 8'h01, 8'h00};
    foreach (seq_bytes[i])
      send_byte(seq_bytes[i]);
  endtask

  // random frames; lengths that would underflow the count are replaced
  task automatic run_capture_traffic(input int n_items);
    int         sent;
    int         r;
    logic [7:0] len;
    logic [7:0] before_rem;
    logic       wrapped;
    parser_t    saved;
    sent = 0;
    while ((sent < n_items ||
            !(psr.fs == ST_IDLE && psr.rem == 8'd0 && !psr.held_v)) &&
           sent < n_items + 400) begin
      if (psr.rem == 8'd0 && !psr.held_v) begin
        r = $urandom_range(99);
        if (r < 6)       len = 8'd0;
        else if (r < 30) len = ACK_LEN;
        else if (r < 88) len = 8'($urandom_range(18, 30));
        else if (r < 97) len = 8'($urandom_range(1, 17));
        else             len = 8'($urandom_range(100, 160));
        if (len != 8'd0) begin
          // trial run of the whole frame on a copy of the parser
          saved = psr;
          format_byte(len);
          wrapped = 1'b0;
          while ((psr.rem != 8'd0 || psr.held_v) && !wrapped) begin
            before_rem = psr.rem;
            format_byte(8'h00);
            wrapped = (psr.rem > before_rem);
          end
          psr = saved;
          byte_chars.delete();
          if (wrapped)
            len = SAFE_FRAME_LEN;
        end
        send_byte(len);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
      sent++;
    end
  endtask

  // a two-byte field with one byte of count left wraps the count to 255
  task automatic test_count_wrap();
    logic [7:0] wrap_bytes [5] = '{8'h01, 8'h3c, 8'hc3, 8'h7e, 8'h81};
    foreach (wrap_bytes[i])
      send_byte(wrap_bytes[i]);
  endtask

  // test sequence
  initial begin
    psr = '{fs: ST_IDLE, rem: 8'd0, ack: 1'b0, held_v: 1'b0, held_b: 8'h00};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_frame();
    test_frame_ends_early();
    wait_chars_drained();

    // no idling
    send_idle_pct = 0;
    stall_pct = 0;
    run_capture_traffic(PHASE_ITEMS);
    wait_chars_drained();

    // sender mostly idle
    send_idle_pct = 81;
    stall_pct = 0;
    run_capture_traffic(PHASE_ITEMS);
    wait_chars_drained();

    // receiver mostly stalled
    send_idle_pct = 0;
    stall_pct = 81;
    run_capture_traffic(PHASE_ITEMS);
    wait_chars_drained();

    // light idling on both sides
    send_idle_pct = 13;
    stall_pct = 13;
    run_capture_traffic(PHASE_ITEMS);
    test_count_wrap();
    wait_chars_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
      $display("sniffed_frame_hex_formatter: match");
    end else begin
      $display("sniffed_frame_hex_formatter: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sfhf_pkg.sv
hw/rtl/sfhf_front.sv
hw/rtl/sfhf_queue.sv
hw/rtl/sfhf_back.sv
hw/rtl/sniffed_frame_hex_formatter.sv
hw/rtl/sfhf_checker.sv
bench/sniffed_frame_hex_formatter_test.sv
